// ===== hw/rtl/htc_pkg.sv =====
// Package for the hashed tile cache table: payload structs, codes and the byte prime table.
// No dependencies.
package htc_pkg;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_SPARE    = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] origin_x;
		logic [63:0] origin_y;
		logic [63:0] origin_z;
		logic [7:0]  res_level;
		logic [31:0] tile_handle;
		logic [31:0] tile_bytes;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] handle_out;
		logic [47:0] total_bytes;
	} rsp_t;

	// One stored entry of the slot memory.
	typedef struct packed {
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] z;
		logic [7:0]  level;
		logic [31:0] handle;
		logic [31:0] size;
		logic [31:0] stamp;
	} slot_t;

	localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;

	function automatic logic [7:0] byte_prime(input logic [4:0] k);
		logic [7:0] p;
		case (k)
			5'd0: p = 8'd101;  5'd1: p = 8'd103;  5'd2: p = 8'd107;  5'd3: p = 8'd109;
			5'd4: p = 8'd113;  5'd5: p = 8'd127;  5'd6: p = 8'd131;  5'd7: p = 8'd137;
			5'd8: p = 8'd139;  5'd9: p = 8'd149;  5'd10: p = 8'd151; 5'd11: p = 8'd157;
			5'd12: p = 8'd163; 5'd13: p = 8'd167; 5'd14: p = 8'd173; 5'd15: p = 8'd179;
			5'd16: p = 8'd181; 5'd17: p = 8'd191; 5'd18: p = 8'd193; 5'd19: p = 8'd197;
			5'd20: p = 8'd199; 5'd21: p = 8'd211; 5'd22: p = 8'd223; 5'd23: p = 8'd227;
			default: p = 8'd0;
		endcase
		return p;
	endfunction

endpackage

// ===== hw/rtl/htc_hash.sv =====
// Key hash unit: one byte times its prime accumulated per cycle over all 24 key bytes,
// then a reciprocal multiply reduces the sum to a bucket. Depends on htc_pkg.
module htc_hash import htc_pkg::*; #(
	parameter int BUCKETS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [191:0]                 key,
	output logic                         done,
	output logic [$clog2(BUCKETS+1)-1:0] bucket
);
	localparam int BW = $clog2(BUCKETS + 1);
	// The byte sum stays below 2^20, so a 20-bit dividend and a shift of
	// 20 + log2(BUCKETS) make the reciprocal quotient exact.
	localparam int QS = 20 + $clog2(BUCKETS);
	localparam longint RECIP_L = ((longint'(1) << QS) + longint'(BUCKETS) - 1)
		/ longint'(BUCKETS);
	localparam logic [21:0] RECIP = 22'(RECIP_L);
	localparam logic [19:0] BK = 20'(BUCKETS);

	logic         run_q;
	logic         fin_q;
	logic [4:0]   idx_q;
	logic [191:0] key_q;
	logic [19:0]  sum_q;
	logic [19:0]  quo_q;
	logic [15:0]  prod;
	logic [41:0]  qprod;
	logic [19:0]  rem;

	assign prod  = 16'(key_q[7:0]) * 16'(byte_prime(idx_q));
	assign qprod = 42'(sum_q) * 42'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			idx_q <= '0;
			done  <= 1'b0;
		end else begin
			if (go) begin
				run_q <= 1'b1;
				idx_q <= '0;
			end else if (run_q) begin
				idx_q <= idx_q + 5'd1;
				if (idx_q == 5'd23) run_q <= 1'b0;
			end
			fin_q <= run_q && !go && (idx_q == 5'd23);
			done  <= fin_q;
		end
	end

	// Byte order x0..x7, y0..y7, z0..z7 matches the prime table order.
	always_ff @(posedge clk) begin
		if (go) begin
			key_q <= key;
			sum_q <= '0;
		end else if (run_q) begin
			key_q <= key_q >> 8;
			sum_q <= sum_q + 20'(prod);
		end
		if (fin_q) quo_q <= 20'(qprod >> QS);
	end

	assign rem    = sum_q - quo_q * BK;
	assign bucket = BW'(rem);
endmodule

// ===== hw/rtl/hashed_tile_cache_table_core.sv =====
// Top level of the hashed tile cache table: sequencer, slot memory and way scan.
// Depends on htc_pkg and htc_hash.
//
// Usage: drive req and pulse start while busy is low; the request beat is taken
// at that edge. busy stays high until the single result beat, marked on rsp by
// done high for one cycle. The receiver cannot stall, so nothing waits.
// Sequence: the accepting edge captures the request, then the key is hashed
// one byte per cycle through one multiplier, a registered reciprocal
// multiply reduces the sum to a bucket, each way of the bucket takes a read
// and a check state on the slot memory, and a write state updates memory
// and totals before the answer state shows the result beat on rsp. busy
// drops after the answer state; a new request waits for the last to finish.
// One request is in work at a time. Bucket ways are visited from way 0
// upward; the oldest match and the lowest free way are tracked on the fly.
// Reset: a clearing pass over all BUCKETS*WAYS slots resets the valid store,
// with busy high, before the first request is taken. Sequence number and
// byte total reset to zero.
module hashed_tile_cache_table_core import htc_pkg::*; #(
	parameter int BUCKETS = 256,
	parameter int WAYS    = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);
	localparam int SLOTS = BUCKETS * WAYS;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int BW    = $clog2(BUCKETS + 1);
	localparam int WW    = $clog2(WAYS + 1);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_HASH  = 7'b0000100,
		S_READ  = 7'b0001000,
		S_CHECK = 7'b0010000,
		S_WRITE = 7'b0100000,
		S_ANS   = 7'b1000000
	} state_t;

	state_t       state_q;
	req_t         req_q;
	logic [AW:0]  clr_q;
	logic [WW-1:0] way_q;
	logic [AW-1:0] base_q;
	logic         hit_q, free_q;
	logic [AW-1:0] hit_a_q, free_a_q;
	logic [31:0]  hit_age_q, hit_handle_q, hit_size_q;
	logic [31:0]  seq_q;
	logic [47:0]  total_q;
	rsp_t         rsp_q;
	logic         done_q;

	slot_t        mem [SLOTS];
	logic         vmem [SLOTS];
	slot_t        rd_q;
	logic         rdv_q;

	logic         hgo, hdone;
	logic [BW-1:0] bucket;

	assign hgo = (state_q == S_IDLE) && start;

	htc_hash #(.BUCKETS(BUCKETS)) u_hash (
		.clk(clk), .arst_n(arst_n), .go(hgo),
		.key({req.origin_z, req.origin_y, req.origin_x}),
		.done(hdone), .bucket(bucket)
	);

	logic [AW-1:0] cur_a;
	logic          match;
	logic [31:0]   age;
	logic          mem_we, mem_ve, mem_vd;
	logic [AW-1:0] mem_wa;
	slot_t         wdata;
	logic [48:0]   sum49;
	rsp_t          rsp_d;
	logic [47:0]   total_d;

	assign cur_a = base_q + AW'(way_q);
	assign match = rdv_q && rd_q.x == req_q.origin_x && rd_q.y == req_q.origin_y
		&& rd_q.z == req_q.origin_z && rd_q.level == req_q.res_level;
	assign age   = seq_q - rd_q.stamp;
	assign sum49 = {1'b0, total_q} + 49'(req_q.tile_bytes);

	assign wdata = '{x: req_q.origin_x, y: req_q.origin_y, z: req_q.origin_z,
		level: req_q.res_level, handle: req_q.tile_handle,
		size: req_q.tile_bytes, stamp: seq_q};

	always_comb begin
		mem_we = 1'b0;
		mem_ve = 1'b0;
		mem_vd = 1'b0;
		mem_wa = free_a_q;
		if (state_q == S_CLEAR) begin
			mem_ve = 1'b1;
			mem_wa = clr_q[AW-1:0];
		end else if (state_q == S_WRITE) begin
			if (req_q.operation == OP_INSERT && free_q) begin
				mem_we = 1'b1;
				mem_ve = 1'b1;
				mem_vd = 1'b1;
			end else if (req_q.operation == OP_REMOVE && hit_q) begin
				mem_ve = 1'b1;
				mem_wa = hit_a_q;
			end
		end
	end

	// Answer and new byte total of the request once the bucket scan is over.
	always_comb begin
		rsp_d   = '{status: ST_NOTFOUND, handle_out: '0, total_bytes: total_q};
		total_d = total_q;
		case (req_q.operation)
			OP_LOOKUP: if (hit_q) begin
				rsp_d.status     = ST_DONE;
				rsp_d.handle_out = hit_handle_q;
			end
			OP_REMOVE: if (hit_q) begin
				rsp_d.status     = ST_DONE;
				rsp_d.handle_out = hit_handle_q;
				total_d = (total_q >= 48'(hit_size_q)) ? total_q - 48'(hit_size_q) : '0;
			end
			OP_INSERT: begin
				if (free_q) begin
					rsp_d.status     = ST_DONE;
					rsp_d.handle_out = req_q.tile_handle;
					total_d = sum49[48] ? TOTAL_MAX : sum49[47:0];
				end else begin
					rsp_d.status = ST_FULL;
				end
			end
			default: ;
		endcase
		rsp_d.total_bytes = total_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= wdata;
		if (mem_ve) vmem[mem_wa] <= mem_vd;
		rd_q  <= mem[cur_a];
		rdv_q <= vmem[cur_a];
	end

	always_ff @(posedge clk) begin
		if (hgo) req_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			way_q   <= '0;
			base_q  <= '0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			hit_a_q <= '0;
			free_a_q <= '0;
			hit_age_q <= '0;
			hit_handle_q <= '0;
			hit_size_q <= '0;
			seq_q   <= '0;
			total_q <= '0;
			rsp_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_WRITE);
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(SLOTS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) state_q <= S_HASH;
				end
				S_HASH: begin
					if (hdone) begin
						base_q  <= AW'(32'(bucket) * 32'(WAYS));
						way_q   <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					// Strictly older wins, so equal ages keep the lower way.
					if (match && (!hit_q || age > hit_age_q)) begin
						hit_q <= 1'b1;
						hit_a_q <= cur_a;
						hit_age_q <= age;
						hit_handle_q <= rd_q.handle;
						hit_size_q <= rd_q.size;
					end
					if (!rdv_q && !free_q) begin
						free_q <= 1'b1;
						free_a_q <= cur_a;
					end
					if (way_q == WW'(WAYS - 1)) begin
						state_q <= S_WRITE;
					end else begin
						way_q <= way_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_WRITE: begin
					rsp_q   <= rsp_d;
					total_q <= total_d;
					if (req_q.operation == OP_INSERT && free_q) seq_q <= seq_q + 32'd1;
					state_q <= S_ANS;
				end
				S_ANS: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;
endmodule
